/* hdl/lrgd_pkg.sv */
// Shared types, constants and helpers for the line-fit gradient descent block.
// No dependencies; imported by the divider, datapath, controller, top level and testbench.
package lrgd_pkg;

  localparam int MAX_SAMPLES = 1024;
  localparam int AW          = $clog2(MAX_SAMPLES);
  localparam int CW          = $clog2(MAX_SAMPLES + 1);

  localparam logic [15:0] LR_RESET    = 16'd6554;
  localparam logic [15:0] EPOCH_RESET = 16'd5000;

  // configuration register indexes
  localparam logic [0:0] CFG_LR     = 1'b0;
  localparam logic [0:0] CFG_EPOCHS = 1'b1;

  // which quantity the divide / update path works on
  typedef enum logic [1:0] {
    SEL_SLOPE,
    SEL_ICPT,
    SEL_ERR
  } lrgd_sel_t;

  // controller -> datapath
  typedef struct packed {
    logic          store_wr;
    logic          rd_en;
    logic [AW-1:0] addr;
    logic          clr_sums;
    logic          err_mode;
    logic          div_start;
    lrgd_sel_t     sel;
    logic          mul_go;
    logic          upd_go;
    logic          load_out;
    logic          clr_params;
    logic          ovf;
    logic [CW-1:0] count;
  } lrgd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic pipe_busy;
    logic div_done;
  } lrgd_sts_t;

  // saturate to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [31:0] r;
    if (v > 50'sd2147483647)       r = 32'sh7FFF_FFFF;
    else if (v < -50'sd2147483648) r = 32'sh8000_0000;
    else                           r = v[31:0];
    return r;
  endfunction

endpackage

/* hdl/lrgd_stream_if.sv */
// Valid/ready stream interfaces for sample beats and result beats.
// Depends on nothing.
interface lrgd_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_x;
  logic signed [15:0] sample_y;
  logic               last_sample;
  modport source (output valid, sample_x, sample_y, last_sample, input ready);
  modport sink   (input valid, sample_x, sample_y, last_sample, output ready);
endinterface

interface lrgd_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] fitted_slope;
  logic signed [31:0] fitted_intercept;
  logic        [31:0] mean_sq_error;
  logic               overflowed;
  modport source (output valid, fitted_slope, fitted_intercept, mean_sq_error, overflowed,
                  input ready);
  modport sink   (input valid, fitted_slope, fitted_intercept, mean_sq_error, overflowed,
                  output ready);
endinterface

/* hdl/lrgd_ram.sv */
// Generic single-port RAM on one shared address: one write, one registered read per cycle.
// No dependencies.
module lrgd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;
endmodule

/* hdl/lrgd_div.sv */
// Restoring divider, one quotient bit per cycle, 64-bit dividend by sample count.
// Depends on lrgd_pkg.
module lrgd_div import lrgd_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [63:0]   dividend,
  input  logic [CW-1:0] divisor,
  output logic [63:0]   quot,
  output logic          done
);
  logic          running_r, done_r;
  logic [5:0]    cnt_r;
  logic [CW-1:0] rem_r;
  logic [63:0]   dq_r;
  logic [CW:0]   shifted, diff;

  assign shifted = {rem_r, dq_r[63]};
  assign diff    = shifted - {1'b0, divisor};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      done_r    <= 1'b0;
      cnt_r     <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        running_r <= 1'b1;
        cnt_r     <= '0;
      end else if (running_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          running_r <= 1'b0;
          done_r    <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dq_r  <= dividend;
    end else if (running_r) begin
      if (!diff[CW]) begin
        rem_r <= diff[CW-1:0];
        dq_r  <= {dq_r[62:0], 1'b1};
      end else begin
        rem_r <= shifted[CW-1:0];
        dq_r  <= {dq_r[62:0], 1'b0};
      end
    end
  end

  assign quot = dq_r;
  assign done = done_r;
endmodule

/* hdl/lrgd_datapath.sv */
// Datapath: sample store, residual pipeline, gradient sums, divide and update.
// Depends on lrgd_pkg, lrgd_ram, lrgd_div.
module lrgd_datapath import lrgd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  lrgd_cmd_t          cmd,
  input  logic [15:0]        lr,
  input  logic signed [15:0] in_x,
  input  logic signed [15:0] in_y,
  output lrgd_sts_t          sts,
  output logic signed [31:0] slope_o,
  output logic signed [31:0] icpt_o,
  output logic [31:0]        mse_o,
  output logic               ovf_o
);
  logic [31:0] ram_q;

  lrgd_ram #(.WIDTH(32), .DEPTH(MAX_SAMPLES)) u_ram (
    .clk   (clk),
    .we    (cmd.store_wr),
    .re    (cmd.rd_en),
    .addr  (cmd.addr),
    .wdata ({in_y, in_x}),
    .rdata (ram_q)
  );

  logic signed [31:0] slope_r, icpt_r;
  logic v1_r, v2_r, v3_r, v4_r;
  logic signed [47:0] sx_r;
  logic signed [15:0] x2_r, y2_r, x3_r;
  logic signed [31:0] r3_r, r4_r;
  logic signed [47:0] gx_r;
  logic signed [63:0] rr_r;
  logic signed [55:0] ssum_r;
  logic signed [47:0] isum_r;
  logic [63:0]        rsq_r;
  logic signed [36:0] pred;
  logic signed [37:0] rfull;

  // pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= cmd.rd_en;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  assign pred  = {sx_r[47], sx_r[47:12]} + {{5{icpt_r[31]}}, icpt_r};
  assign rfull = {{10{y2_r[15]}}, y2_r, 12'b0} - {pred[36], pred};

  // residual pipeline: slope*x, residual, products
  always_ff @(posedge clk) begin
    sx_r <= $signed(slope_r) * $signed(ram_q[15:0]);
    x2_r <= ram_q[15:0];
    y2_r <= ram_q[31:16];
    r3_r <= sat32({{12{rfull[37]}}, rfull});
    x3_r <= x2_r;
    gx_r <= $signed(x3_r) * $signed(r3_r);
    rr_r <= $signed(r3_r) * $signed(r3_r);
    r4_r <= r3_r;
  end

  // accumulators
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_sums) begin
      ssum_r <= '0;
      isum_r <= '0;
      rsq_r  <= '0;
    end else if (v4_r) begin
      if (cmd.err_mode) begin
        rsq_r <= rsq_r + {24'b0, rr_r[63:24]};
      end else begin
        ssum_r <= ssum_r + {{20{gx_r[47]}}, gx_r[47:12]};
        isum_r <= isum_r + {{16{r4_r[31]}}, r4_r};
      end
    end
  end

  // divide operand select, magnitude of signed sums
  logic [55:0] s_abs;
  logic [47:0] i_abs;
  logic [63:0] dividend, quot;
  logic        div_done, neg_r;

  assign s_abs = ssum_r[55] ? (~ssum_r + 56'd1) : ssum_r;
  assign i_abs = isum_r[47] ? (~isum_r + 48'd1) : isum_r;

  always_comb begin
    case (cmd.sel)
      SEL_SLOPE: dividend = {8'b0, s_abs};
      SEL_ICPT:  dividend = {16'b0, i_abs};
      default:   dividend = rsq_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      neg_r <= (cmd.sel == SEL_SLOPE) ? ssum_r[55] :
               (cmd.sel == SEL_ICPT)  ? isum_r[47] : 1'b0;
    end
  end

  lrgd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (cmd.count),
    .quot     (quot),
    .done     (div_done)
  );

  // step = floor(mean * 2 * lr / 2^16), product in two halves
  logic signed [47:0] mean;
  logic [16:0]        lr2;
  logic [40:0]        plo_r;
  logic signed [40:0] phi_r;
  logic signed [64:0] prod;
  logic signed [48:0] step;
  logic signed [31:0] param;
  logic signed [31:0] upd;

  assign mean = neg_r ? -$signed(quot[47:0]) : $signed(quot[47:0]);
  assign lr2  = {lr, 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.mul_go) begin
      plo_r <= mean[23:0] * lr2;
      phi_r <= $signed(mean[47:24]) * $signed({1'b0, lr2});
    end
  end

  assign prod  = $signed({phi_r, 24'b0}) + $signed({24'b0, plo_r});
  assign step  = prod[64:16];
  assign param = (cmd.sel == SEL_SLOPE) ? slope_r : icpt_r;
  assign upd   = sat32({{18{param[31]}}, param} + {step[48], step});

  // fitted parameters
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_params) begin
      slope_r <= '0;
      icpt_r  <= '0;
    end else if (cmd.upd_go) begin
      if (cmd.sel == SEL_SLOPE) begin
        slope_r <= upd;
      end else begin
        icpt_r <= upd;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      slope_o <= slope_r;
      icpt_o  <= icpt_r;
      mse_o   <= (quot[63:32] != 32'd0) ? 32'hFFFF_FFFF : quot[31:0];
      ovf_o   <= cmd.ovf;
    end
  end

  assign sts.pipe_busy = v1_r | v2_r | v3_r | v4_r;
  assign sts.div_done  = div_done;
endmodule

/* hdl/lrgd_ctrl.sv */
// Controller: load, epoch sweeps, divide/update sequence, final error and result.
// Depends on lrgd_pkg.
module lrgd_ctrl import lrgd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_last,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] epochs,
  input  lrgd_sts_t   sts,
  output lrgd_cmd_t   cmd
);
  typedef enum logic [3:0] {
    ST_LOAD, ST_CLR, ST_SWEEP, ST_DRAIN, ST_DIV, ST_DIVWAIT, ST_MUL, ST_UPD, ST_RESULT
  } state_t;

  state_t        state_r;
  logic [CW-1:0] count_r;
  logic [AW-1:0] addr_r;
  logic [15:0]   epoch_r;
  lrgd_sel_t     sel_r;
  logic          err_r, ovf_r, out_valid_r;
  logic          accept, room, out_free;
  logic [CW-1:0] last_addr;

  assign accept    = in_valid && (state_r == ST_LOAD);
  assign room      = (count_r != CW'(MAX_SAMPLES));
  assign out_free  = !out_valid_r || out_ready;
  assign last_addr = count_r - CW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      addr_r      <= '0;
      epoch_r     <= '0;
      sel_r       <= SEL_SLOPE;
      err_r       <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // result beat taken and nothing new loaded this cycle
      if (out_ready && !cmd.load_out) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_LOAD: begin
          if (accept) begin
            if (room) count_r <= count_r + CW'(1);
            else      ovf_r   <= 1'b1;
            if (in_last) begin
              epoch_r <= '0;
              err_r   <= (epochs == 16'd0);
              state_r <= ST_CLR;
            end
          end
        end
        ST_CLR: begin
          addr_r  <= '0;
          sel_r   <= err_r ? SEL_ERR : SEL_SLOPE;
          state_r <= ST_SWEEP;
        end
        ST_SWEEP: begin
          addr_r <= addr_r + AW'(1);
          if (CW'(addr_r) == last_addr) state_r <= ST_DRAIN;
        end
        ST_DRAIN: begin
          if (!sts.pipe_busy) state_r <= ST_DIV;
        end
        ST_DIV: state_r <= ST_DIVWAIT;
        ST_DIVWAIT: begin
          if (sts.div_done) state_r <= (sel_r == SEL_ERR) ? ST_RESULT : ST_MUL;
        end
        ST_MUL: state_r <= ST_UPD;
        ST_UPD: begin
          if (sel_r == SEL_SLOPE) begin
            sel_r   <= SEL_ICPT;
            state_r <= ST_DIV;
          end else begin
            epoch_r <= epoch_r + 16'd1;
            if ({1'b0, epoch_r} + 17'd1 == {1'b0, epochs}) err_r <= 1'b1;
            state_r <= ST_CLR;
          end
        end
        ST_RESULT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            count_r     <= '0;
            ovf_r       <= 1'b0;
            state_r     <= ST_LOAD;
          end
        end
        default: state_r <= ST_LOAD;
      endcase
    end
  end

  // command decode
  always_comb begin
    cmd.store_wr   = accept && room;
    cmd.rd_en      = (state_r == ST_SWEEP);
    cmd.addr       = (state_r == ST_SWEEP) ? addr_r : count_r[AW-1:0];
    cmd.clr_sums   = (state_r == ST_CLR);
    cmd.err_mode   = err_r;
    cmd.div_start  = (state_r == ST_DIV);
    cmd.sel        = sel_r;
    cmd.mul_go     = (state_r == ST_MUL);
    cmd.upd_go     = (state_r == ST_UPD);
    cmd.load_out   = (state_r == ST_RESULT) && out_free;
    cmd.clr_params = (state_r == ST_RESULT) && out_free;
    cmd.ovf        = ovf_r;
    cmd.count      = count_r;
  end

  assign in_ready  = (state_r == ST_LOAD);
  assign out_valid = out_valid_r;
endmodule

/* hdl/linear_regression_gradient_descent.sv */
// Top level: line fit by batch gradient descent over stored samples.
// Depends on lrgd_pkg, lrgd_stream_if, lrgd_ctrl, lrgd_datapath.
//
//   channel   | dir | beat
//   in_chan   | in  | sample_x, sample_y (Q4.12), last_sample
//   out_chan  | out | fitted_slope, fitted_intercept, mean_sq_error, overflowed
//   cfg_*     | in  | index 0 learning_rate, index 1 epoch_count
//
// Samples load at one per cycle while the block is in its load state. After the last
// beat the fit runs E epochs over N samples before the result is loaded: one store
// read per sample per epoch, then two divides per epoch in the shared divider.
// Synchronous active-low reset; the sample store holds no reset state.
// A waiting result lets the next batch load but stalls that fit's result and the following load.
module linear_regression_gradient_descent import lrgd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  lrgd_in_if.sink     in_chan,
  lrgd_out_if.source  out_chan,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  logic [15:0] lr_r, epochs_r;
  lrgd_cmd_t   cmd;
  lrgd_sts_t   sts;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r     <= LR_RESET;
      epochs_r <= EPOCH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LR:     lr_r     <= cfg_wdata;
        CFG_EPOCHS: epochs_r <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  lrgd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_last   (in_chan.last_sample),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .epochs    (epochs_r),
    .sts       (sts),
    .cmd       (cmd)
  );

  lrgd_datapath u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .lr      (lr_r),
    .in_x    (in_chan.sample_x),
    .in_y    (in_chan.sample_y),
    .sts     (sts),
    .slope_o (out_chan.fitted_slope),
    .icpt_o  (out_chan.fitted_intercept),
    .mse_o   (out_chan.mean_sq_error),
    .ovf_o   (out_chan.overflowed)
  );

`ifndef SYNTHESIS
  // no store write while a sweep reads the store
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |-> !cmd.store_wr) else $error("store read and write together");
  // divides start only once the residual pipeline has drained
  a_div_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !sts.pipe_busy) else $error("divide while pipeline busy");
  // loading a result presents it next cycle
  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_chan.valid) else $error("result not presented");
  // samples are only taken with the pipeline idle
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |-> !sts.pipe_busy) else $error("load during sweep");
`endif
endmodule

/* tb/lrgd_fit_scoreboard.sv */
// Scoreboard for the line-fit block: predicts each fit result from the beats
// accepted on the sample channel. Depends on lrgd_pkg.
class lrgd_fit_scoreboard;
  typedef struct {
    logic signed [31:0] slope;
    logic signed [31:0] icpt;
    logic [31:0]        mse;
    logic               ovf;
  } fit_result_t;

  shortint     xs[lrgd_pkg::MAX_SAMPLES];
  shortint     ys[lrgd_pkg::MAX_SAMPLES];
  int unsigned held;
  bit          dropped;
  int unsigned rate;
  int unsigned epochs;
  fit_result_t pending_fits[$];
  int          mismatches;

  function new();
    held       = 0;
    dropped    = 0;
    rate       = lrgd_pkg::LR_RESET;
    epochs     = lrgd_pkg::EPOCH_RESET;
    mismatches = 0;
  endfunction

  function void set_reg(logic [0:0] idx, logic [15:0] v);
    if (idx == lrgd_pkg::CFG_LR) rate = v;
    else                         epochs = v;
  endfunction

  function int clip32(longint v);
    if (v > 64'sd2147483647)       return 32'sh7FFF_FFFF;
    else if (v < -64'sd2147483648) return 32'sh8000_0000;
    return int'(v);
  endfunction

  // residual of sample i for the given parameters, Q8.24
  function int residual(int slope, int icpt, int unsigned i);
    longint pred;
    pred = ((longint'(slope) * longint'(xs[i])) >>> 12) + icpt;
    return clip32(longint'(ys[i]) * 4096 - pred);
  endfunction

  function int stepped(int p, longint grad_sum);
    longint avg;
    longint stp;
    avg = grad_sum / longint'(held);
    stp = (avg * longint'(rate) * 2) >>> 16;
    return clip32(longint'(p) + stp);
  endfunction

  // one accepted sample beat; a last mark runs the whole fit
  function void note_sample(shortint x, shortint y, bit last);
    int               slope;
    int               icpt;
    int               r;
    longint           gs;
    longint           gi;
    longint unsigned  sq;
    longint unsigned  m;
    fit_result_t      res;
    if (held < lrgd_pkg::MAX_SAMPLES) begin
      xs[held] = x;
      ys[held] = y;
      held++;
    end else begin
      dropped = 1;
    end
    if (!last) return;
    slope = 0;
    icpt  = 0;
    for (int unsigned e = 0; e < epochs; e++) begin
      gs = 0;
      gi = 0;
      for (int unsigned i = 0; i < held; i++) begin
        r  = residual(slope, icpt, i);
        gs += (longint'(xs[i]) * longint'(r)) >>> 12;
        gi += r;
      end
      slope = stepped(slope, gs);
      icpt  = stepped(icpt, gi);
    end
    sq = 0;
    for (int unsigned i = 0; i < held; i++) begin
      r  = residual(slope, icpt, i);
      sq += longint'(unsigned'((longint'(r) * longint'(r)) >>> 24));
    end
    m = sq / longint'(held);
    if (m > 64'hFFFF_FFFF) m = 64'hFFFF_FFFF;
    res.slope = slope;
    res.icpt  = icpt;
    res.mse   = m[31:0];
    res.ovf   = dropped;
    pending_fits.push_back(res);
    held    = 0;
    dropped = 0;
  endfunction

  // one accepted result beat
  function void check_fit(logic [31:0] slope, logic [31:0] icpt, logic [31:0] mse,
                          logic ovf);
    fit_result_t want;
    if (pending_fits.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result beat: slope %h icpt %h mse %h ovf %b",
                 slope, icpt, mse, ovf);
      return;
    end
    want = pending_fits.pop_front();
    if (slope !== want.slope || icpt !== want.icpt || mse !== want.mse ||
        ovf !== want.ovf) begin
      mismatches++;
      if (mismatches <= 10)
        $display("fit mismatch: exp slope %h icpt %h mse %h ovf %b, got %h %h %h %b",
                 want.slope, want.icpt, want.mse, want.ovf, slope, icpt, mse, ovf);
    end
  endfunction
endclass

/* tb/linear_regression_gradient_descent_tb.sv */
// Testbench top for the line-fit block: directed and random sample batches,
// register changes between batches, stalls on both channels.
// Depends on lrgd_pkg, lrgd_stream_if, lrgd_fit_scoreboard and the RTL.
module linear_regression_gradient_descent_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lrgd_pkg::*;

  localparam int WATCHDOG_CYCLES = 3_000_000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [15:0] cfg_wdata;

  lrgd_in_if  in_chan ();
  lrgd_out_if out_chan ();

  linear_regression_gradient_descent uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  lrgd_fit_scoreboard fits = new();

  int src_idle_pct;
  int snk_idle_pct;
  bit snk_hold;
  int quiet_cycles;

  always #6 clk = ~clk;

  // receiver ready, changed on the falling edge
  always @(negedge clk) begin
    out_chan.ready = !snk_hold && ($urandom_range(99) >= snk_idle_pct);
  end

  // result monitor and watchdog
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready)
      fits.check_fit(out_chan.fitted_slope, out_chan.fitted_intercept,
                     out_chan.mean_sq_error, out_chan.overflowed);
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // one sample beat; valid stays high into the next beat unless idling
  task automatic send_sample(logic [15:0] x, logic [15:0] y, logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      in_chan.valid = 1'b0;
      @(negedge clk);
    end
    in_chan.valid       = 1'b1;
    in_chan.sample_x    = x;
    in_chan.sample_y    = y;
    in_chan.last_sample = last;
    do @(posedge clk); while (!in_chan.ready);
    fits.note_sample(x, y, last);
    @(negedge clk);
  endtask

  // let the block drain before a register write
  task automatic wait_idle();
    in_chan.valid = 1'b0;
    while (fits.pending_fits.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [15:0] v);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    fits.set_reg(idx, v);
  endtask

  function automatic logic [15:0] pick_q();
    case ($urandom_range(3))
      0:       return 16'($urandom());
      1:       return 16'($signed($urandom_range(8192)) - 4096);
      2:       return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
      default: return 16'($signed($urandom_range(1024)) - 512);
    endcase
  endfunction

  // well-formed batch: n beats, only the final one marked last
  task automatic send_batch(int n);
    for (int i = 0; i < n; i++)
      send_sample(pick_q(), pick_q(), i == n - 1);
  endtask

  initial begin
    int sent;
    int n;
    clk                 = 1'b0;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = CFG_LR;
    cfg_wdata           = '0;
    in_chan.valid       = 1'b0;
    in_chan.sample_x    = '0;
    in_chan.sample_y    = '0;
    in_chan.last_sample = 1'b0;
    out_chan.ready      = 1'b0;
    src_idle_pct        = 0;
    snk_idle_pct        = 0;
    snk_hold            = 1'b0;
    quiet_cycles        = 0;
    n                   = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset register values, single sample at the corners
    send_sample(16'h7FFF, 16'h8000, 1'b1);
    wait_idle();

    // zero epochs, largest step
    write_reg(CFG_LR, 16'hFFFF);
    write_reg(CFG_EPOCHS, 16'd0);
    send_sample(16'h8000, 16'h7FFF, 1'b0);
    send_sample(16'h7FFF, 16'h8000, 1'b1);
    wait_idle();

    // zero step, one epoch
    write_reg(CFG_LR, 16'd0);
    write_reg(CFG_EPOCHS, 16'd1);
    send_sample(16'h0000, 16'h0000, 1'b1);
    wait_idle();

    // largest step over a few epochs, saturating parameters
    write_reg(CFG_LR, 16'hFFFF);
    write_reg(CFG_EPOCHS, 16'd3);
    send_sample(16'h8000, 16'h8000, 1'b0);
    send_sample(16'h7FFF, 16'h7FFF, 1'b0);
    send_sample(16'h0001, 16'hFFFF, 1'b0);
    send_sample(16'h1000, 16'h2000, 1'b1);
    wait_idle();

    // random batches in three idling modes
    for (int mode = 0; mode < 3; mode++) begin
      src_idle_pct = (mode == 0) ? 30 : (mode == 1) ? 87 : 0;
      snk_idle_pct = (mode == 0) ? 87 : (mode == 1) ? 30 : 0;
      for (int sub = 0; sub < 2; sub++) begin
        write_reg(CFG_LR, 16'($urandom()));
        write_reg(CFG_EPOCHS, 16'($urandom_range(8, 1)));
        if (mode == 2 && sub == 0) begin
          // long receiver hold-off so the block backs up into the input
          fork
            begin
              snk_hold = 1'b1;
              repeat (4000) @(posedge clk);
              snk_hold = 1'b0;
            end
          join_none
        end
        sent = 0;
        while (sent < 16) begin
          if ($urandom_range(9) == 0) n = int'($urandom_range(16, 9));
          else                        n = int'($urandom_range(6, 1));
          send_batch(n);
          sent += n;
        end
        wait_idle();
      end
    end

    repeat (50) @(negedge clk);
    if (fits.mismatches == 0 && fits.pending_fits.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

/* files.f */
hdl/lrgd_pkg.sv
hdl/lrgd_stream_if.sv
hdl/lrgd_ram.sv
hdl/lrgd_div.sv
hdl/lrgd_datapath.sv
hdl/lrgd_ctrl.sv
hdl/linear_regression_gradient_descent.sv
tb/lrgd_fit_scoreboard.sv
tb/linear_regression_gradient_descent_tb.sv
